// File: design/assert_macros.svh
// Assertion macros shared by the predictor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// Check that cond implies prop in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

// File: design/gbp_pkg.sv
// Shared types, constants and functions of the gshare/BTB predictor.
package gbp_pkg;

	localparam int HISTORY_BITS_DEF   = 8;
	localparam int BTB_INDEX_BITS_DEF = 10;
	localparam int PC_W               = 64;
	localparam int CNT_W              = 2;
	localparam logic [PC_W-1:0] INST_BYTES = PC_W'(4);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef enum logic {
		REQ_PREDICT = 1'b0,
		REQ_UPDATE  = 1'b1
	} req_t;

	// Controller to datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic exec;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic clear_done;
	} status_t;

	typedef struct packed {
		logic            valid;
		logic            cond;
		logic [PC_W-1:0] tag;
		logic [PC_W-1:0] target;
	} btb_entry_t;

	// Saturating 2-bit counter step.
	function automatic logic [CNT_W-1:0] cnt_step(input logic [CNT_W-1:0] cnt,
		input logic taken);
		logic [CNT_W-1:0] res;
		res = cnt;
		if (taken) begin
			if (cnt != '1)
				res = cnt + CNT_W'(1);
		end else begin
			if (cnt != '0)
				res = cnt - CNT_W'(1);
		end
		return res;
	endfunction

endpackage

// File: design/gshare_btb_branch_predictor.sv
// Top level of the gshare direction predictor with a direct-mapped BTB.
//
// After reset the block sweeps its BTB and counter memories, one entry of each
// per cycle, over all 2^max(HISTORY_BITS, BTB_INDEX_BITS) clear addresses (1024 at the
// defaults); busy stays high for that whole pass. Afterwards a request is
// taken on a clock edge with start high and busy low, and each request
// occupies the block for a read step, which reads both memories, and an
// execute step, which resolves the hit and writes back; busy stays high in
// the execute step, so a new request is taken only once the last is through.
// A predict request produces one beat: done pulses for one cycle, the cycle
// after the execute cycle, with next_pc valid; the receiver cannot stall that
// beat, so capture it when done is high. An update request produces no beat.
`include "assert_macros.svh"

module gshare_btb_branch_predictor #(
	parameter int HISTORY_BITS   = gbp_pkg::HISTORY_BITS_DEF,
	parameter int BTB_INDEX_BITS = gbp_pkg::BTB_INDEX_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     req_type,
	input  logic [gbp_pkg::PC_W-1:0] pc,
	input  logic [gbp_pkg::PC_W-1:0] target,
	input  logic                     conditional,
	input  logic                     taken,
	output logic                     done,
	output logic [gbp_pkg::PC_W-1:0] next_pc
);

	gbp_pkg::cmd_t    cmd;
	gbp_pkg::status_t status;

	// Sequence the clear pass and each request.
	gbp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold memories, history and the result register.
	gbp_dp #(
		.HISTORY_BITS   (HISTORY_BITS),
		.BTB_INDEX_BITS (BTB_INDEX_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.req_type    (req_type),
		.pc          (pc),
		.target      (target),
		.conditional (conditional),
		.taken       (taken),
		.done        (done),
		.next_pc     (next_pc)
	);

	`ASSERT_NEXT(a_accept_sets_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`ASSERT_SAME(a_done_when_idle, clk, arst_n, done, !busy)

endmodule

// File: design/gbp_ctrl.sv
// Controller state machine of the predictor: clear pass, accept, execute.
`include "assert_macros.svh"

module gbp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  gbp_pkg::status_t status,
	output gbp_pkg::cmd_t   cmd,
	output logic            busy
);

	gbp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gbp_pkg::ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd.clear = 1'b0;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		busy      = 1'b1;
		unique case (state_q)
			gbp_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_done)
					state_d = gbp_pkg::ST_IDLE;
			end
			gbp_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = gbp_pkg::ST_EXEC;
				end
			end
			gbp_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = gbp_pkg::ST_IDLE;
			end
			default: begin
				state_d = gbp_pkg::ST_IDLE;
			end
		endcase
	end

	`ASSERT_NEXT(a_load_then_exec, clk, arst_n, cmd.load, state_q == gbp_pkg::ST_EXEC)
	`ASSERT_NEXT(a_exec_then_idle, clk, arst_n, cmd.exec, !busy)
	`ASSERT_SAME(a_cmd_exclusive, clk, arst_n, 1'b1, $onehot0({cmd.clear, cmd.load, cmd.exec}))

endmodule

// File: design/gbp_dp.sv
// Datapath of the predictor: BTB and counter memories, history, next-PC logic.
module gbp_dp #(
	parameter int HISTORY_BITS   = gbp_pkg::HISTORY_BITS_DEF,
	parameter int BTB_INDEX_BITS = gbp_pkg::BTB_INDEX_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gbp_pkg::cmd_t            cmd,
	output gbp_pkg::status_t         status,
	input  logic                     req_type,
	input  logic [gbp_pkg::PC_W-1:0] pc,
	input  logic [gbp_pkg::PC_W-1:0] target,
	input  logic                     conditional,
	input  logic                     taken,
	output logic                     done,
	output logic [gbp_pkg::PC_W-1:0] next_pc
);

	localparam int PHT_DEPTH = 1 << HISTORY_BITS;
	localparam int BTB_DEPTH = 1 << BTB_INDEX_BITS;
	localparam int CLR_BITS  = (HISTORY_BITS > BTB_INDEX_BITS) ? HISTORY_BITS : BTB_INDEX_BITS;

	gbp_pkg::btb_entry_t        btb_mem [BTB_DEPTH];
	logic [gbp_pkg::CNT_W-1:0]  pht_mem [PHT_DEPTH];

	logic [CLR_BITS-1:0]          clr_q;
	logic [HISTORY_BITS-1:0]      history_q;
	logic                         req_q, cond_q, taken_q;
	logic [gbp_pkg::PC_W-1:0]     pc_q, target_q;
	logic [HISTORY_BITS-1:0]      pht_idx_q;
	gbp_pkg::btb_entry_t          btb_rd_q;
	logic [gbp_pkg::CNT_W-1:0]    cnt_rd_q;
	logic                         done_q;
	logic [gbp_pkg::PC_W-1:0]     next_pc_q;

	logic [BTB_INDEX_BITS-1:0]    btb_ra, btb_wa;
	logic [HISTORY_BITS-1:0]      pht_ra, pht_wa;
	logic                         btb_we, pht_we;
	gbp_pkg::btb_entry_t          btb_wd;
	logic [gbp_pkg::CNT_W-1:0]    pht_wd;
	logic                         hit, use_target, is_update;
	logic [gbp_pkg::PC_W-1:0]     pred_pc;

	assign btb_ra = pc[BTB_INDEX_BITS+1:2];
	assign pht_ra = history_q ^ pc[HISTORY_BITS+1:2];

	assign is_update  = (req_q == gbp_pkg::REQ_UPDATE);
	assign hit        = btb_rd_q.valid && (btb_rd_q.tag == pc_q);
	assign use_target = hit && (!btb_rd_q.cond || cnt_rd_q[gbp_pkg::CNT_W-1]);
	assign pred_pc    = use_target ? btb_rd_q.target : pc_q + gbp_pkg::INST_BYTES;

	// Memory write selection: the clear pass and execute never overlap.
	always_comb begin
		btb_we = 1'b0;
		pht_we = 1'b0;
		btb_wa = pc_q[BTB_INDEX_BITS+1:2];
		pht_wa = pht_idx_q;
		btb_wd.valid  = 1'b1;
		btb_wd.cond   = cond_q;
		btb_wd.tag    = pc_q;
		btb_wd.target = target_q;
		pht_wd = gbp_pkg::cnt_step(cnt_rd_q, taken_q);
		if (cmd.clear) begin
			btb_we = 1'b1;
			pht_we = 1'b1;
			btb_wa = clr_q[BTB_INDEX_BITS-1:0];
			pht_wa = clr_q[HISTORY_BITS-1:0];
			btb_wd = '0;
			pht_wd = '0;
		end else if (cmd.exec && is_update) begin
			btb_we = 1'b1;
			pht_we = cond_q;
		end
	end

	always_ff @(posedge clk) begin
		if (btb_we)
			btb_mem[btb_wa] <= btb_wd;
		if (cmd.load)
			btb_rd_q <= btb_mem[btb_ra];
	end

	always_ff @(posedge clk) begin
		if (pht_we)
			pht_mem[pht_wa] <= pht_wd;
		if (cmd.load)
			cnt_rd_q <= pht_mem[pht_ra];
	end

	// Hold the request for the execute cycle.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req_type;
			pc_q      <= pc;
			target_q  <= target;
			cond_q    <= conditional;
			taken_q   <= taken;
			pht_idx_q <= pht_ra;
		end
		if (cmd.exec)
			next_pc_q <= pred_pc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			history_q <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cmd.clear)
				clr_q <= clr_q + CLR_BITS'(1);
			if (cmd.exec && is_update && cond_q)
				history_q <= {history_q[HISTORY_BITS-2:0], taken_q};
			done_q <= cmd.exec && !is_update;
		end
	end

	assign status.clear_done = cmd.clear && (clr_q == '1);
	assign done    = done_q;
	assign next_pc = next_pc_q;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the gshare/BTB next-PC predictor.
module testbench;

	localparam int PC_W         = gbp_pkg::PC_W;
	localparam int CNT_W        = gbp_pkg::CNT_W;
	localparam int HIST_W       = gbp_pkg::HISTORY_BITS_DEF;
	localparam int BTB_IDX_W    = gbp_pkg::BTB_INDEX_BITS_DEF;
	localparam int CTR_SLOTS    = 2 ** HIST_W;
	localparam int BTB_SLOTS    = 2 ** BTB_IDX_W;
	localparam int RESET_CYCLES = 12;
	localparam int MAX_GAP      = 17;
	localparam int RANDOM_ITEMS = 925;
	localparam int POOL_SIZE    = 32;
	localparam int DRAIN_LIMIT  = 100;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;
	localparam logic [CNT_W-1:0] CTR_MAX      = '1;
	localparam logic [CNT_W-1:0] CTR_MIN      = '0;
	localparam logic [CNT_W-1:0] CTR_TAKEN_AT = CNT_W'(2);

	// Drive every input to a known value from time zero.
	logic            clk         = 1'b0;
	logic            arst_n      = 1'b0;
	logic            start       = 1'b0;
	logic            req_type    = gbp_pkg::REQ_PREDICT;
	logic [PC_W-1:0] pc          = '0;
	logic [PC_W-1:0] target      = '0;
	logic            conditional = 1'b0;
	logic            taken       = 1'b0;
	logic            busy;
	logic            done;
	logic [PC_W-1:0] next_pc;

	gshare_btb_branch_predictor DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.pc         (pc),
		.target     (target),
		.conditional(conditional),
		.taken      (taken),
		.done       (done),
		.next_pc    (next_pc)
	);

	always #1 clk = ~clk;

	// Shadow copy of the predictor state, advanced on every accepted update beat.
	logic [HIST_W-1:0] ghist;
	logic [CNT_W-1:0]  dir_ctr    [CTR_SLOTS];
	logic              btb_v      [BTB_SLOTS];
	logic [PC_W-1:0]   btb_pc_tag [BTB_SLOTS];
	logic              btb_cond   [BTB_SLOTS];
	logic [PC_W-1:0]   btb_dest   [BTB_SLOTS];

	// Next-PC values owed by the block, oldest first.
	logic [PC_W-1:0] next_pc_due [$];
	logic [PC_W-1:0] due_pc;
	int              mismatches = 0;
	int              burst_left = 0;

	function automatic logic [PC_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// gshare: history folded onto the word-address bits of the PC.
	function automatic logic [HIST_W-1:0] ctr_slot(input logic [PC_W-1:0] addr);
		return ghist ^ addr[HIST_W+1:2];
	endfunction

	function automatic logic [BTB_IDX_W-1:0] btb_slot(input logic [PC_W-1:0] addr);
		return addr[BTB_IDX_W+1:2];
	endfunction

	// Fall through to the sequential address unless the BTB hits with the
	// full tag and the branch is unconditional or predicted taken.
	function automatic logic [PC_W-1:0] predict_next_pc(input logic [PC_W-1:0] addr);
		logic [BTB_IDX_W-1:0] b;
		logic [PC_W-1:0]      seq;
		b   = btb_slot(addr);
		seq = addr + gbp_pkg::INST_BYTES;
		if (!btb_v[b] || btb_pc_tag[b] != addr)
			return seq;
		if (!btb_cond[b] || dir_ctr[ctr_slot(addr)] >= CTR_TAKEN_AT)
			return btb_dest[b];
		return seq;
	endfunction

	// Rewrite the BTB entry; for a conditional branch step the counter with
	// the old history, then shift the outcome in.
	task automatic train_predictor(input logic [PC_W-1:0] addr, input logic [PC_W-1:0] dest,
		input logic is_cond, input logic was_taken);
		logic [BTB_IDX_W-1:0] b;
		logic [HIST_W-1:0]    s;
		b = btb_slot(addr);
		btb_v[b]      = 1'b1;
		btb_pc_tag[b] = addr;
		btb_cond[b]   = is_cond;
		btb_dest[b]   = dest;
		if (is_cond) begin
			s = ctr_slot(addr);
			if (was_taken && dir_ctr[s] != CTR_MAX)
				dir_ctr[s] = dir_ctr[s] + CNT_W'(1);
			else if (!was_taken && dir_ctr[s] != CTR_MIN)
				dir_ctr[s] = dir_ctr[s] - CNT_W'(1);
			ghist = {ghist[HIST_W-2:0], was_taken};
		end
	endtask

	task automatic report_mismatch(input string what, input logic [PC_W-1:0] exp_pc,
		input logic [PC_W-1:0] act_pc);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch: %s, expected next_pc %h, got %h", what, exp_pc, act_pc);
	endtask

	// Send one request beat after a random gap, and fold it into the shadow
	// state at the edge where the block takes it.
	task automatic send_item(input gbp_pkg::req_t kind, input logic [PC_W-1:0] addr,
		input logic [PC_W-1:0] dest, input logic is_cond, input logic was_taken);
		int gap;
		// Mostly random gaps, with occasional back-to-back bursts.
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, MAX_GAP);
			if ($urandom_range(0, 15) == 0)
				burst_left = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		req_type    <= kind;
		pc          <= addr;
		target      <= dest;
		conditional <= is_cond;
		taken       <= was_taken;
		// Hold the beat until an edge sees busy low; that edge takes it.
		do @(posedge clk); while (busy !== 1'b0);
		if (kind == gbp_pkg::REQ_PREDICT)
			next_pc_due.push_back(predict_next_pc(addr));
		else
			train_predictor(addr, dest, is_cond, was_taken);
	endtask

	// Empty BTB: every lookup falls through, including the wrap past the top.
	task automatic test_cold_misses();
		send_item(gbp_pkg::REQ_PREDICT, '0, '1, 1'b1, 1'b1);
		send_item(gbp_pkg::REQ_PREDICT, '1, '0, 1'b0, 1'b0);
		send_item(gbp_pkg::REQ_PREDICT, {{(PC_W-2){1'b1}}, 2'b00}, rand64(), 1'b1, 1'b0);
	endtask

	// Tag match, tag miss on the same slot, eviction, and a conditional entry
	// whose counter holds at strongly not taken.
	task automatic test_unconditional_hits();
		logic [PC_W-1:0] a;
		logic [PC_W-1:0] b;
		a = 64'h8000_0000_0040_0124;
		b = a ^ 64'h7FFF_FFFF_FFFF_F000;
		send_item(gbp_pkg::REQ_UPDATE,  a, '1, 1'b1, 1'b0);
		send_item(gbp_pkg::REQ_PREDICT, a, '0, 1'b1, 1'b1);
		send_item(gbp_pkg::REQ_UPDATE,  a, '1, 1'b0, 1'b1);
		send_item(gbp_pkg::REQ_PREDICT, a, '0, 1'b0, 1'b0);
		send_item(gbp_pkg::REQ_PREDICT, a ^ (PC_W'(1) << (BTB_IDX_W + 2)), '1, 1'b1, 1'b1);
		send_item(gbp_pkg::REQ_UPDATE,  b, '0, 1'b0, 1'b0);
		send_item(gbp_pkg::REQ_PREDICT, b, '1, 1'b1, 1'b1);
		send_item(gbp_pkg::REQ_PREDICT, a, '1, 1'b0, 1'b1);
	endtask

	// Taken streak: history fills with ones, then the same counter is hit
	// repeatedly and pins at strongly taken.
	task automatic test_counter_saturation();
		logic [PC_W-1:0] p;
		logic [PC_W-1:0] dest;
		p    = 64'h0000_7FFF_FFFF_FF3C;
		dest = 64'h5555_AAAA_5555_AAA8;
		for (int i = 0; i < 12; i++)
			send_item(gbp_pkg::REQ_UPDATE, p, dest, 1'b1, 1'b1);
		send_item(gbp_pkg::REQ_PREDICT, p, '0, 1'b0, 1'b0);
	endtask

	// Random traffic over a pool of branches that alias in the BTB and in the
	// counter table, mixed with stray addresses and lookups near the top.
	task automatic test_random_traffic();
		logic [PC_W-1:0] pool_pc   [POOL_SIZE];
		logic [PC_W-1:0] pool_dest [POOL_SIZE];
		logic            pool_cond [POOL_SIZE];
		int              pool_bias [POOL_SIZE];
		int              pick;
		int              roll;
		for (int i = 0; i < POOL_SIZE; i++) begin
			case (i % 4)
				1: pool_pc[i] = pool_pc[i-1] ^ (rand64() << (BTB_IDX_W + 2)) ^
					(PC_W'(1) << (PC_W - 1));
				2: pool_pc[i] = pool_pc[i-2] ^ (PC_W'(1) << (HIST_W + 2));
				default: pool_pc[i] = rand64();
			endcase
			pool_dest[i] = rand64();
			pool_cond[i] = (i % 3 != 0);
			pool_bias[i] = $urandom_range(0, 2) * 45 + 5;
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, POOL_SIZE - 1);
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				send_item(gbp_pkg::REQ_PREDICT, pool_pc[pick], rand64(),
					1'($urandom), 1'($urandom));
			end else if (roll < 85) begin
				// Retarget a branch now and then; rarely flip its kind.
				if ($urandom_range(0, 9) == 0)
					pool_dest[pick] = rand64();
				if ($urandom_range(0, 19) == 0)
					pool_cond[pick] = ~pool_cond[pick];
				send_item(gbp_pkg::REQ_UPDATE, pool_pc[pick], pool_dest[pick],
					pool_cond[pick], $urandom_range(0, 99) < pool_bias[pick]);
			end else if (roll < 92) begin
				send_item(gbp_pkg::REQ_PREDICT, rand64(), rand64(),
					1'($urandom), 1'($urandom));
			end else if (roll < 96) begin
				send_item(gbp_pkg::REQ_UPDATE, rand64(), rand64(),
					1'($urandom), 1'($urandom));
			end else begin
				send_item(gbp_pkg::REQ_PREDICT, '1 - PC_W'($urandom_range(0, 7)), rand64(),
					1'($urandom), 1'($urandom));
			end
		end
	endtask

	// Each done beat is taken at the edge ending its cycle; match it against
	// the oldest owed value.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (next_pc_due.size() == 0) begin
				report_mismatch("beat with nothing owed", 'x, next_pc);
			end else begin
				due_pc = next_pc_due.pop_front();
				if (next_pc !== due_pc)
					report_mismatch("wrong next_pc", due_pc, next_pc);
			end
		end
	end

	initial begin
		ghist = '0;
		foreach (dir_ctr[i])
			dir_ctr[i] = CTR_MIN;
		foreach (btb_v[i]) begin
			btb_v[i]      = 1'b0;
			btb_pc_tag[i] = '0;
			btb_cond[i]   = 1'b0;
			btb_dest[i]   = '0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		// The first beat simply waits out the clearing pass behind busy.
		test_cold_misses();
		test_unconditional_hits();
		test_counter_saturation();
		test_random_traffic();
		start <= 1'b0;
		// Drain owed beats, then let the block settle.
		for (int w = 0; w < DRAIN_LIMIT && next_pc_due.size() != 0; w++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (next_pc_due.size() != 0)
			report_mismatch("beat never arrived", next_pc_due.pop_front(), 'x);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#500000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
